@@ hw/rtl/timed_event_queue_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the timed event queue
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_TOP_DEFINES_SVH
`define TIMED_EVENT_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define TEQ_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/teq_pkg.sv @@
// ---------------------------------------------------------------------------
// teq_pkg
// Types and constants shared by the timed event queue modules.
// ---------------------------------------------------------------------------
package teq_pkg;

   localparam int OP_W     = 2;
   localparam int ID_W     = 16;
   localparam int TIME_W   = 64;
   localparam int SEQ_W    = 32;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

   typedef enum logic [OP_W-1:0] {
      OP_POST   = 2'd0,
      OP_CANCEL = 2'd1,
      OP_POLL   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_POSTED    = 3'd0,
      ST_DISABLED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_FIRED     = 3'd3,
      ST_NONE_DUE  = 3'd4,
      ST_CANCELLED = 3'd5,
      ST_ABSENT    = 3'd6
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   id;
      logic [SEQ_W-1:0]  seq_num;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic setup;
      logic step;
      logic commit;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic immediate;
      logic scan_done;
   } sts_type;

endpackage

@@ hw/rtl/teq_if.sv @@
// ---------------------------------------------------------------------------
// teq_req_if / teq_rsp_if
// Valid/ready channels for request and response transactions.
// ---------------------------------------------------------------------------
interface teq_req_if import teq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [ID_W-1:0]          evt_id;
   logic signed [TIME_W-1:0] deadline;
   logic signed [TIME_W-1:0] now_time;

   modport source (output valid, op, evt_id, deadline, now_time, input ready);
   modport sink   (input valid, op, evt_id, deadline, now_time, output ready);
endinterface

interface teq_rsp_if import teq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ID_W-1:0]          fired_id;
   logic [SEQ_W-1:0]         sequence_res;
   logic signed [TIME_W-1:0] fired_deadline;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, status, fired_id, sequence_res, fired_deadline,
                   occupancy, input ready);
   modport sink   (input valid, status, fired_id, sequence_res, fired_deadline,
                   occupancy, output ready);
endinterface

@@ hw/rtl/timed_event_queue_top.sv @@
// Deadline-ordered event queue. Entries sit in one memory sorted by signed deadline, ties in
// arrival order. Each request transaction is handled alone. Posts, cancels and polls walk the
// held entries through the memory's single read port at one entry per cycle; a rejected post
// or an unused op skips the walk. The next request can be taken in the cycle after the
// response is loaded. The finished response sits in an output register, so a new request
// is taken while the previous response waits. The enable register gates posts only and is
// written through csr_wr_en / csr_wr_data; the user must write it only while the queue is
// idle, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
// timed_event_queue_top
// Top level: controller, datapath, request/response channels and checks.
// ---------------------------------------------------------------------------
`include "timed_event_queue_top_defines.svh"

module timed_event_queue_top import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   teq_req_if.sink      req_ch,
   teq_rsp_if.source    rsp_ch
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type       cmd;
   sts_type       sts;
   logic [CW-1:0] occ_count;

   teq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   teq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_ch.op),
      .req_evt_id         (req_ch.evt_id),
      .req_deadline       (req_ch.deadline),
      .req_now_time       (req_ch.now_time),
      .rsp_status         (rsp_ch.status),
      .rsp_fired_id       (rsp_ch.fired_id),
      .rsp_sequence_res   (rsp_ch.sequence_res),
      .rsp_fired_deadline (rsp_ch.fired_deadline),
      .rsp_occupancy      (rsp_ch.occupancy),
      .occ_count          (occ_count)
   );

   `TEQ_ASSERT_NEXT(a_one_request_at_a_time, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
   `TEQ_ASSERT_HOLDS(a_rsp_load_when_free, cmd.load_rsp, !rsp_ch.valid || rsp_ch.ready, "response overwritten")
   `TEQ_ASSERT_NEXT(a_count_in_range, cmd.commit, occ_count <= CW'(QUEUE_DEPTH), "occupancy past depth")

endmodule

@@ hw/rtl/teq_ram.sv @@
// ---------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/teq_ctrl.sv @@
// ---------------------------------------------------------------------------
// teq_ctrl
// Sequencing state machine and response valid flag.
// ---------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_COMMIT = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.setup = 1'b1;
            state_in  = sts.immediate ? S_RESULT : S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_COMMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            // response slot frees up when empty or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/teq_dpath.sv @@
// ---------------------------------------------------------------------------
// teq_dpath
// Entry memory, scan pointers, ordered insert / compaction and result regs.
// ---------------------------------------------------------------------------
module teq_dpath import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  cmd_type                         cmd,
   output sts_type                         sts,
   input  logic [OP_W-1:0]                 req_op,
   input  logic [ID_W-1:0]                 req_evt_id,
   input  logic [TIME_W-1:0]               req_deadline,
   input  logic [TIME_W-1:0]               req_now_time,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [ID_W-1:0]                 rsp_fired_id,
   output logic [SEQ_W-1:0]                rsp_sequence_res,
   output logic [TIME_W-1:0]               rsp_fired_deadline,
   output logic [OCC_W-1:0]                rsp_occupancy,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] occ_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   // configuration and queue state
   logic              enable_ff, enable_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   // captured transaction
   op_type            op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] dl_ff, dl_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // scan state
   logic [CW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     pend_idx_ff, pend_idx_in;
   logic [CW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic              stop_ff, stop_in;
   logic              hit_ff, hit_in;

   // staged result
   status_type        res_status_ff, res_status_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [SEQ_W-1:0]  res_seq_ff, res_seq_in;
   logic [TIME_W-1:0] res_dl_ff, res_dl_in;

   // response payload
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [SEQ_W-1:0]    rsp_seq_ff, rsp_seq_in;
   logic [TIME_W-1:0]   rsp_dl_ff, rsp_dl_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   // memory port
   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;

   entry_type         new_entry;
   logic              is_full;
   logic              new_before;
   logic              head_due;
   logic              issue;

   teq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_ptr_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   assign new_entry  = '{deadline: dl_ff, id: id_ff, seq_num: seq_ff};
   assign is_full    = (count_ff == CW'(QUEUE_DEPTH));
   // new deadline strictly earlier than the entry read back
   assign new_before = $signed(dl_ff) < $signed(ram_rdata.deadline);
   assign head_due   = ram_rdata.deadline[TIME_W-1] || (ram_rdata.deadline == TIME_MAX) ||
                       !($signed(now_ff) < $signed(ram_rdata.deadline));
   assign issue      = cmd.step && (rd_cnt_ff != '0) && !stop_ff;

   assign sts.immediate = (op_ff == OP_NONE) || ((op_ff == OP_POST) && (!enable_ff || is_full));
   assign sts.scan_done = stop_ff || ((rd_cnt_ff == '0) && !pend_ff);

   always_comb begin
      enable_in     = csr_wr_en ? csr_wr_data : enable_ff;
      count_in      = count_ff;
      seq_in        = seq_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      dl_in         = dl_ff;
      now_in        = now_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      stop_in       = stop_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_seq_in    = res_seq_ff;
      res_dl_in     = res_dl_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = new_entry;

      if (cmd.capture) begin
         op_in  = op_type'(req_op);
         id_in  = req_evt_id;
         dl_in  = req_deadline;
         now_in = req_now_time;
      end

      if (cmd.setup) begin
         res_id_in   = '0;
         res_seq_in  = '0;
         res_dl_in   = '0;
         pend_in     = 1'b0;
         stop_in     = 1'b0;
         hit_in      = 1'b0;
         wr_ptr_in   = '0;
         rd_cnt_in   = count_ff;
         // inserts walk down from the tail, cancel/poll walk up from the head
         rd_ptr_in   = (op_ff == OP_POST) ? count_ff - CW'(1) : '0;
         if (op_ff == OP_NONE) begin
            res_status_in = ST_NONE_DUE;
         end else if (!enable_ff) begin
            res_status_in = ST_DISABLED;
         end else begin
            res_status_in = ST_FULL;
         end
      end

      if (cmd.step) begin
         pend_in     = issue;
         pend_idx_in = rd_ptr_ff;
         if (issue) begin
            rd_cnt_in = rd_cnt_ff - CW'(1);
            rd_ptr_in = (op_ff == OP_POST) ? rd_ptr_ff - CW'(1) : rd_ptr_ff + CW'(1);
         end
         if (pend_ff && !stop_ff) begin
            case (op_ff)
               OP_POST: begin
                  ram_we    = 1'b1;
                  ram_waddr = IW'(pend_idx_ff + CW'(1));
                  if (new_before) begin
                     ram_wdata = ram_rdata;
                  end else begin
                     ram_wdata = new_entry;
                     stop_in   = 1'b1;
                  end
               end
               OP_CANCEL: begin
                  if (ram_rdata.id == id_ff) begin
                     hit_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = wr_ptr_ff[IW-1:0];
                     ram_wdata = ram_rdata;
                     wr_ptr_in = wr_ptr_ff + CW'(1);
                  end
               end
               OP_POLL: begin
                  if (pend_idx_ff == '0) begin
                     if (head_due) begin
                        hit_in     = 1'b1;
                        res_id_in  = ram_rdata.id;
                        res_seq_in = ram_rdata.seq_num;
                        res_dl_in  = ram_rdata.deadline;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = wr_ptr_ff[IW-1:0];
                     ram_wdata = ram_rdata;
                     wr_ptr_in = wr_ptr_ff + CW'(1);
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd.commit) begin
         case (op_ff)
            OP_POST: begin
               // not placed during the walk: new entry becomes the head
               if (!stop_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = new_entry;
               end
               count_in      = count_ff + CW'(1);
               seq_in        = seq_ff + SEQ_W'(1);
               res_seq_in    = seq_ff;
               res_status_in = ST_POSTED;
            end
            OP_CANCEL: begin
               count_in      = wr_ptr_ff;
               res_status_in = hit_ff ? ST_CANCELLED : ST_ABSENT;
            end
            OP_POLL: begin
               if (hit_ff) begin
                  count_in      = count_ff - CW'(1);
                  res_status_in = ST_FIRED;
               end else begin
                  res_status_in = ST_NONE_DUE;
               end
            end
            default: res_status_in = ST_NONE_DUE;
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_status_in = res_status_ff;
         rsp_id_in     = res_id_ff;
         rsp_seq_in    = res_seq_ff;
         rsp_dl_in     = res_dl_ff;
         rsp_occ_in    = OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         seq_ff    <= '0;
         pend_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         rd_cnt_ff <= '0;
      end else begin
         enable_ff <= enable_in;
         count_ff  <= count_in;
         seq_ff    <= seq_in;
         pend_ff   <= pend_in;
         stop_ff   <= stop_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      dl_ff         <= dl_in;
      now_ff        <= now_in;
      rd_ptr_ff     <= rd_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      wr_ptr_ff     <= wr_ptr_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_seq_ff    <= res_seq_in;
      res_dl_ff     <= res_dl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_fired_id       = rsp_id_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_fired_deadline = rsp_dl_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign occ_count          = count_ff;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: timed event queue testbench
// Drives post, cancel and poll transactions through the request channel,
// predicts each response with a shadow copy of the deadline-ordered queue and
// checks every response field in order. Both channels idle in random bursts;
// one phase holds the response side off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import teq_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic [TIME_W-1:0] T_ONES = '1;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   evt_id;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now_time;
   } request_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   fired_id;
      logic [SEQ_W-1:0]  sequence_res;
      logic [TIME_W-1:0] fired_deadline;
      logic [OCC_W-1:0]  occupancy;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   teq_req_if req_ch ();
   teq_rsp_if rsp_ch ();

   timed_event_queue_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow copy of the queue, sorted by signed deadline
   entry_type         shadow_entries[$];
   logic [SEQ_W-1:0]  shadow_seq = '0;
   bit                shadow_enable = 1'b0;

   request_type       request_backlog[$];
   outcome_type       outcome_q[$];
   request_type       in_flight;
   outcome_type       seen;
   outcome_type       want;
   int unsigned       send_gap = 0;
   int unsigned       recv_gap = 0;
   int unsigned       hold_left = 0;
   int unsigned       mismatches = 0;
   bit                calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic outcome_type queue_outcome(request_type rq);
      outcome_type       res;
      entry_type         ent;
      logic [TIME_W-1:0] head;
      int                pos;
      bit                hit;
      res = '0;
      res.status = ST_NONE_DUE;
      case (rq.op)
         OP_POST: begin
            if (!shadow_enable) begin
               res.status = ST_DISABLED;
            end else if (shadow_entries.size() >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_entries.size() &&
                      !($signed(rq.deadline) < $signed(shadow_entries[pos].deadline)))
                  pos++;
               ent.deadline = rq.deadline;
               ent.id = rq.evt_id;
               ent.seq_num = shadow_seq;
               shadow_entries.insert(pos, ent);
               res.sequence_res = shadow_seq;
               shadow_seq++;
               res.status = ST_POSTED;
            end
         end
         OP_CANCEL: begin
            pos = 0;
            hit = 1'b0;
            while (pos < shadow_entries.size()) begin
               if (shadow_entries[pos].id == rq.evt_id) begin
                  shadow_entries.delete(pos);
                  hit = 1'b1;
               end else begin
                  pos++;
               end
            end
            res.status = hit ? ST_CANCELLED : ST_ABSENT;
         end
         OP_POLL: begin
            if (shadow_entries.size() != 0) begin
               head = shadow_entries[0].deadline;
               // negative and maximal deadlines are always due
               if (head[TIME_W-1] || head == TIME_MAX ||
                   !($signed(rq.now_time) < $signed(head))) begin
                  res.fired_id = shadow_entries[0].id;
                  res.sequence_res = shadow_entries[0].seq_num;
                  res.fired_deadline = head;
                  shadow_entries.delete(0);
                  res.status = ST_FIRED;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(shadow_entries.size());
      return res;
   endfunction

   function automatic request_type req_item(op_type op, logic [ID_W-1:0] id,
                                            logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
      request_type rq;
      rq.op = op;
      rq.evt_id = id;
      rq.deadline = dl;
      rq.now_time = now;
      return rq;
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      logic [TIME_W-1:0] t;
      case ($urandom_range(0, 9))
         0: t = {$urandom, $urandom};
         1: begin
            case ($urandom_range(0, 4))
               0:       t = T_MIN;
               1:       t = TIME_MAX;
               2:       t = TIME_MAX - 1;
               3:       t = T_ONES;
               default: t = '0;
            endcase
         end
         2: t = '0 - TIME_W'($urandom_range(1, 1000));
         default: t = TIME_W'($urandom_range(0, 1000));
      endcase
      return t;
   endfunction

   function automatic request_type random_request(int post_w, int cancel_w);
      request_type rq;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < post_w)
         rq.op = OP_POST;
      else if (pick < post_w + cancel_w)
         rq.op = OP_CANCEL;
      else if (pick < 95)
         rq.op = OP_POLL;
      else
         rq.op = OP_NONE;
      // a small id pool makes cancels hit and repeat
      rq.evt_id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
      rq.deadline = random_time();
      rq.now_time = random_time();
      return rq;
   endfunction

   task automatic wait_idle();
      while (request_backlog.size() != 0 || req_ch.valid || outcome_q.size() != 0)
         @(negedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic set_enable(bit value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_enable = value;
   endtask

   task automatic random_phase(bit en, int count, int post_w, int cancel_w, bit quiet,
                               int unsigned hold);
      set_enable(en);
      if (hold != 0)
         hold_left <= hold;
      @(negedge clock);
      calm = quiet;
      repeat (count) request_backlog.push_back(random_request(post_w, cancel_w));
      wait_idle();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            outcome_q.push_back(queue_outcome(in_flight));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               in_flight = request_backlog.pop_front();
               req_ch.op <= in_flight.op;
               req_ch.evt_id <= in_flight.evt_id;
               req_ch.deadline <= in_flight.deadline;
               req_ch.now_time <= in_flight.now_time;
               req_ch.valid <= 1'b1;
               if (!calm && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off
   always @(posedge clock) begin
      if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status = status_type'(rsp_ch.status);
            seen.fired_id = rsp_ch.fired_id;
            seen.sequence_res = rsp_ch.sequence_res;
            seen.fired_deadline = rsp_ch.fired_deadline;
            seen.occupancy = rsp_ch.occupancy;
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response transaction with none outstanding, status %0d",
                           $realtime, rsp_ch.status);
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: want st=%0d id=%h seq=%h dl=%h occ=%0d", $realtime,
                              want.status, want.fired_id, want.sequence_res,
                              want.fired_deadline, want.occupancy);
                     $display("%0t: got  st=%0d id=%h seq=%h dl=%h occ=%0d", $realtime,
                              rsp_ch.status, seen.fired_id, seen.sequence_res,
                              seen.fired_deadline, seen.occupancy);
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
               recv_gap = $urandom_range(1, 11);
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.op = '0;
      req_ch.evt_id = '0;
      req_ch.deadline = '0;
      req_ch.now_time = '0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: posts rejected, empty queue
      @(negedge clock);
      request_backlog.push_back(req_item(OP_POST, 16'hFFFF, TIME_MAX, '0));
      request_backlog.push_back(req_item(OP_CANCEL, 16'h0000, '0, '0));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, T_MIN));
      request_backlog.push_back(req_item(OP_NONE, 16'hFFFF, T_ONES, T_ONES));
      wait_idle();

      set_enable(1'b1);
      @(negedge clock);
      // equal deadlines with one id, then the extremes
      repeat (3) request_backlog.push_back(req_item(OP_POST, 16'h0007, 64'd100, '0));
      request_backlog.push_back(req_item(OP_POST, 16'h0000, T_MIN, '0));
      request_backlog.push_back(req_item(OP_POST, 16'hFFFF, TIME_MAX, '0));
      request_backlog.push_back(req_item(OP_POST, 16'h0001, T_ONES, '0));
      request_backlog.push_back(req_item(OP_POST, 16'h0002, '0, '0));
      request_backlog.push_back(req_item(OP_POST, 16'h0003, TIME_MAX - 1, '0));
      // negative heads fire even at the earliest time
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, T_MIN));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, T_MIN));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, T_MIN));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, '0));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, 64'd99));
      // adjacent matches all go
      request_backlog.push_back(req_item(OP_CANCEL, 16'h0007, '0, '0));
      request_backlog.push_back(req_item(OP_CANCEL, 16'h0007, '0, '0));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, '0));
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, TIME_MAX));
      // a maximal deadline is due at any time
      request_backlog.push_back(req_item(OP_POLL, 16'h0000, '0, T_MIN));
      request_backlog.push_back(req_item(OP_NONE, 16'h0000, '0, '0));
      wait_idle();

      random_phase(1'b1, 300, 60, 10, 1'b0, 0);
      random_phase(1'b0, 80, 40, 15, 1'b0, 0);
      random_phase(1'b1, 300, 45, 15, 1'b0, 400);
      random_phase(1'b1, 270, 35, 15, 1'b1, 0);

      if (mismatches == 0 && outcome_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
